// ===== design/llpy_pkg.sv =====
// llpy_pkg: shared types, constants and the arctangent table of the look-at block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package llpy_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int SQ_CELLS = 32;
	localparam int DW = 33;
	localparam int XW = 36;
	localparam int ZW = 33;
	localparam int AW = 20;

	localparam logic signed [AW-1:0] PI_Q16 = 20'sd205887;
	localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;

	typedef enum logic [1:0] {
		SEL_CORDIC   = 2'd0,
		SEL_ZERO     = 2'd1,
		SEL_POS_HALF = 2'd2,
		SEL_NEG_HALF = 2'd3
	} ang_sel_t;

	typedef struct packed {
		logic                   unch;
		ang_sel_t               p_sel;
		ang_sel_t               y_sel;
		logic                   add_pi;
		logic signed [31:0]     p_y;
		logic signed [XW-1:0]   yaw_x;
		logic signed [XW-1:0]   yaw_y;
	} side_t;

	// atan(2^-i) in q2.30
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 33'sd843314857;
			1: v = 33'sd497837829;
			2: v = 33'sd263043837;
			3: v = 33'sd133525159;
			4: v = 33'sd67021687;
			5: v = 33'sd33543516;
			6: v = 33'sd16775851;
			7: v = 33'sd8388437;
			8: v = 33'sd4194283;
			9: v = 33'sd2097149;
			10: v = 33'sd1048576;
			11: v = 33'sd524288;
			12: v = 33'sd262144;
			13: v = 33'sd131072;
			14: v = 33'sd65536;
			15: v = 33'sd32768;
			16: v = 33'sd16384;
			17: v = 33'sd8192;
			18: v = 33'sd4096;
			19: v = 33'sd2048;
			20: v = 33'sd1024;
			21: v = 33'sd512;
			22: v = 33'sd256;
			23: v = 33'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/llpy_if.sv =====
// llpy_req_if / llpy_rsp_if: valid-ready channels of the look-at block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface llpy_req_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	modport source(output valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
		input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
		output ready);
endinterface

interface llpy_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] pitch_angle;
	logic signed [19:0] yaw_angle;
	logic               unchanged;
	modport source(output valid, pitch_angle, yaw_angle, unchanged, input ready);
	modport sink(input valid, pitch_angle, yaw_angle, unchanged, output ready);
endinterface
`default_nettype wire

// ===== design/llpy_sqrt_cell.sv =====
// llpy_sqrt_cell: one result bit of the restoring integer square root
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module llpy_sqrt_cell #(
	parameter int BIT_POS = 31
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] rem_in,
	input  wire logic [63:0] root_in,
	output logic      [63:0] rem_q,
	output logic      [63:0] root_q
);
	localparam logic [63:0] BIT = 64'd1 << (2 * BIT_POS);

	logic [64:0] trial;
	assign trial = {1'b0, root_in} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, rem_in} >= trial) begin
				rem_q  <= rem_in - trial[63:0];
				root_q <= (root_in >> 1) + BIT;
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in >> 1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/llpy_cordic_cell.sv =====
// llpy_cordic_cell: one vectoring micro-rotation with a fixed shift
// depends on llpy_pkg
`timescale 1ns / 1ps
`default_nettype none
module llpy_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [llpy_pkg::XW-1:0] x_in,
	input  wire logic signed [llpy_pkg::XW-1:0] y_in,
	input  wire logic signed [llpy_pkg::ZW-1:0] z_in,
	output logic      signed [llpy_pkg::XW-1:0] x_q,
	output logic      signed [llpy_pkg::XW-1:0] y_q,
	output logic      signed [llpy_pkg::ZW-1:0] z_q
);
	localparam logic signed [llpy_pkg::ZW-1:0] ATAN = llpy_pkg::atan_q30(SHIFT);

	logic signed [llpy_pkg::XW-1:0] xs, ys;
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[llpy_pkg::XW-1]) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/look_at_pitch_yaw.sv =====
// look_at_pitch_yaw: top level, difference, square root chain, two cordic chains
// depends on llpy_pkg, llpy_if, llpy_sqrt_cell, llpy_cordic_cell
//
// channel  dir  payload
// req      in   pos_x, pos_y, pos_z, target_x, target_y, target_z (q16.16)
// rsp      out  pitch_angle, yaw_angle (q3.16), unchanged
//
// one item per cycle through the difference, multiply and sum stages,
// 32 square root cells, the cordic cells and the output register. arst_n
// clears the valid bits only. when rsp holds a result that is not taken,
// the whole chain holds and req.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module look_at_pitch_yaw #(
	parameter int CORDIC_STEPS = llpy_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	llpy_req_if.sink   req,
	llpy_rsp_if.source rsp
);
	localparam int SQ = llpy_pkg::SQ_CELLS;
	localparam int L = 3 + SQ + CORDIC_STEPS;
	localparam int XW = llpy_pkg::XW;
	localparam int ZW = llpy_pkg::ZW;
	localparam int DW = llpy_pkg::DW;

	logic en;
	logic out_v_q;
	assign en = !out_v_q || rsp.ready;
	assign req.ready = en;

	// stage 1: exact differences
	logic v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(req.pos_x) - DW'(req.target_x);
			dy_s1 <= DW'(req.pos_y) - DW'(req.target_y);
			dz_s1 <= DW'(req.pos_z) - DW'(req.target_z);
		end
	end

	// stage 2 prep: magnitudes, halving, case flags
	logic [DW-1:0] mx, my, mz;
	logic          big;
	logic [30:0]   a_c, b_c, c_c;
	llpy_pkg::side_t side_c;

	always_comb begin
		mx = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		my = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		mz = dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);
		big = (|mx[32:31]) || (|my[32:31]) || (|mz[32:31]);
		a_c = big ? mx[31:1] : mx[30:0];
		b_c = big ? mz[31:1] : mz[30:0];
		c_c = big ? my[31:1] : my[30:0];
		side_c.unch = (dx_s1 == '0) && (dy_s1 == '0) && (dz_s1 == '0);
		if (dy_s1 == '0) begin
			side_c.p_sel = llpy_pkg::SEL_ZERO;
		end else if (dx_s1 == '0 && dz_s1 == '0) begin
			side_c.p_sel = dy_s1[DW-1] ? llpy_pkg::SEL_NEG_HALF : llpy_pkg::SEL_POS_HALF;
		end else begin
			side_c.p_sel = llpy_pkg::SEL_CORDIC;
		end
		if (dx_s1 == '0) begin
			side_c.y_sel = llpy_pkg::SEL_ZERO;
		end else if (dz_s1 == '0) begin
			side_c.y_sel = dx_s1[DW-1] ? llpy_pkg::SEL_NEG_HALF : llpy_pkg::SEL_POS_HALF;
		end else begin
			side_c.y_sel = llpy_pkg::SEL_CORDIC;
		end
		side_c.add_pi = !dz_s1[DW-1] && (dz_s1 != '0);
		side_c.p_y = dy_s1[DW-1] ? -$signed({1'b0, c_c}) : $signed({1'b0, c_c});
		// yaw vector is mirrored into the right half plane
		side_c.yaw_x = dz_s1[DW-1] ? -XW'(dz_s1) : XW'(dz_s1);
		side_c.yaw_y = dz_s1[DW-1] ? -XW'(dx_s1) : XW'(dx_s1);
	end

	// side line carries flags and valid alongside the cells
	llpy_pkg::side_t side_q [L];
	logic [L-1:0]    v_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_line_q <= '0;
		end else if (en) begin
			v_line_q <= {v_line_q[L-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_c;
			for (int j = 1; j < L; j++) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	// stages 2 to 4: squares and their sum
	logic [30:0] a_s2, b_s2;
	logic [61:0] aa_s3, bb_s3;
	logic [63:0] n_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= a_c;
			b_s2  <= b_c;
			aa_s3 <= a_s2 * a_s2;
			bb_s3 <= b_s2 * b_s2;
			n_s4  <= {2'b00, aa_s3} + {2'b00, bb_s3};
		end
	end

	// square root chain, one result bit per cell
	logic [63:0] rem_w  [SQ+1];
	logic [63:0] root_w [SQ+1];
	assign rem_w[0]  = n_s4;
	assign root_w[0] = '0;

	for (genvar k = 0; k < SQ; k++) begin : g_sq
		llpy_sqrt_cell #(
			.BIT_POS(SQ - 1 - k)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_in (rem_w[k]),
			.root_in(root_w[k]),
			.rem_q  (rem_w[k+1]),
			.root_q (root_w[k+1])
		);
	end

	// cordic chains for pitch and yaw in lockstep
	logic signed [XW-1:0] px_w [CORDIC_STEPS+1];
	logic signed [XW-1:0] py_w [CORDIC_STEPS+1];
	logic signed [ZW-1:0] pz_w [CORDIC_STEPS+1];
	logic signed [XW-1:0] yx_w [CORDIC_STEPS+1];
	logic signed [XW-1:0] yy_w [CORDIC_STEPS+1];
	logic signed [ZW-1:0] yz_w [CORDIC_STEPS+1];

	assign px_w[0] = $signed({{(XW-32){1'b0}}, root_w[SQ][31:0]});
	assign py_w[0] = XW'(side_q[2+SQ].p_y);
	assign pz_w[0] = '0;
	assign yx_w[0] = side_q[2+SQ].yaw_x;
	assign yy_w[0] = side_q[2+SQ].yaw_y;
	assign yz_w[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cd
		llpy_cordic_cell #(
			.SHIFT(i)
		) u_pitch (
			.clk (clk),
			.en  (en),
			.x_in(px_w[i]),
			.y_in(py_w[i]),
			.z_in(pz_w[i]),
			.x_q (px_w[i+1]),
			.y_q (py_w[i+1]),
			.z_q (pz_w[i+1])
		);
		llpy_cordic_cell #(
			.SHIFT(i)
		) u_yaw (
			.clk (clk),
			.en  (en),
			.x_in(yx_w[i]),
			.y_in(yy_w[i]),
			.z_in(yz_w[i]),
			.x_q (yx_w[i+1]),
			.y_q (yy_w[i+1]),
			.z_q (yz_w[i+1])
		);
	end

	// rounding to q3.16 and case selection
	llpy_pkg::side_t      sf;
	logic signed [ZW-1:0] pr, yr;
	logic signed [19:0]   pitch_c, yaw_c, yaw_base;

	function automatic logic signed [19:0] pick(input llpy_pkg::ang_sel_t s,
		input logic signed [19:0] c);
		logic signed [19:0] v;
		unique case (s)
			llpy_pkg::SEL_CORDIC:   v = c;
			llpy_pkg::SEL_ZERO:     v = '0;
			llpy_pkg::SEL_POS_HALF: v = llpy_pkg::HALF_PI_Q16;
			llpy_pkg::SEL_NEG_HALF: v = -llpy_pkg::HALF_PI_Q16;
			default:                v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		sf = side_q[L-1];
		pr = (pz_w[CORDIC_STEPS] + 33'sd8192) >>> 14;
		yr = (yz_w[CORDIC_STEPS] + 33'sd8192) >>> 14;
		yaw_base = pick(sf.y_sel, yr[19:0]);
		if (sf.unch) begin
			pitch_c = '0;
			yaw_c   = '0;
		end else begin
			pitch_c = pick(sf.p_sel, pr[19:0]);
			yaw_c   = sf.add_pi ? yaw_base + llpy_pkg::PI_Q16 : yaw_base;
		end
	end

	logic signed [19:0] pitch_q, yaw_q;
	logic               unch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_line_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= pitch_c;
			yaw_q   <= yaw_c;
			unch_q  <= sf.unch;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.pitch_angle = pitch_q;
	assign rsp.yaw_angle   = yaw_q;
	assign rsp.unchanged   = unch_q;

`ifndef SYNTHESIS
	a_unch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && unch_q |-> pitch_q == '0 && yaw_q == '0)
		else $error("unchanged item with nonzero angle");
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_line_q[L-1] |=> out_v_q)
		else $error("item lost at output register");
	a_hold_line: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_line_q) && $stable(v_s1))
		else $error("pipeline moved during stall");
`endif
endmodule
`default_nettype wire

// ===== bench/look_at_pitch_yaw_tb.sv =====
// look_at_pitch_yaw_tb: regression bench for the look-at pitch/yaw block
// drives random and directed position/target items, checks angles against a
// bit-exact predictor; depends on llpy_pkg, llpy_if and the design files
`timescale 1ns / 1ps
`default_nettype none
module look_at_pitch_yaw_tb;

	localparam int STEPS = llpy_pkg::CORDIC_STEPS_DEF;
	localparam int LATENCY = 4 + 32 + STEPS + 1;

	typedef struct packed {
		logic signed [19:0] pitch;
		logic signed [19:0] yaw;
		logic               unch;
	} angles_t;

	typedef struct {
		logic [31:0] px, py, pz, tx, ty, tz;
		logic        known;
		angles_t     want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	llpy_req_if req();
	llpy_rsp_if rsp();

	look_at_pitch_yaw dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	angles_t angles_due[$];
	int errors = 0;
	int checked = 0;
	int send_idle = 0;
	int recv_idle = 0;

	// q2.30 arctangent of 2^-i
	function automatic longint atan_step(input int i);
		longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128};
		return tab[i];
	endfunction

	function automatic longint vec_atan(input longint x0, input longint y0);
		longint x, y, z, xs, ys;
		x = x0;
		y = y0;
		z = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += atan_step(i);
			end else begin
				x -= ys;
				y += xs;
				z -= atan_step(i);
			end
		end
		return (z + 8192) >>> 14;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned rem, root, b;
		rem = n;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic angles_t look_angles(input logic [31:0] px, py, pz, tx, ty, tz);
		longint dx, dy, dz, pitch, yaw, r;
		longint unsigned a, b, c;
		angles_t res;
		dx = longint'($signed(px)) - longint'($signed(tx));
		dy = longint'($signed(py)) - longint'($signed(ty));
		dz = longint'($signed(pz)) - longint'($signed(tz));
		pitch = 0;
		yaw = 0;
		if (dx == 0 && dy == 0 && dz == 0) begin
			res.pitch = '0;
			res.yaw = '0;
			res.unch = 1'b1;
			return res;
		end
		if (dy != 0) begin
			if (dx == 0 && dz == 0) begin
				pitch = dy > 0 ? 102944 : -102944;
			end else begin
				a = dx < 0 ? -dx : dx;
				b = dz < 0 ? -dz : dz;
				c = dy < 0 ? -dy : dy;
				// wide differences are halved to keep the sum of squares in range
				if (a >= 64'd1 << 31 || b >= 64'd1 << 31 || c >= 64'd1 << 31) begin
					a >>= 1;
					b >>= 1;
					c >>= 1;
				end
				r = floor_sqrt(a * a + b * b);
				pitch = vec_atan(r, dy < 0 ? -longint'(c) : longint'(c));
			end
		end
		if (dx != 0) begin
			if (dz == 0) yaw = dx > 0 ? 102944 : -102944;
			else if (dz > 0) yaw = vec_atan(dz, dx);
			else yaw = vec_atan(-dz, -dx);
		end
		if (dz > 0) yaw += 205887;
		res.pitch = pitch[19:0];
		res.yaw = yaw[19:0];
		res.unch = 1'b0;
		return res;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 8) - 4;
			3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [31:0] px, py, pz, tx, ty, tz);
		while ($urandom_range(0, 99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.pos_x <= px;
		req.pos_y <= py;
		req.pos_z <= pz;
		req.target_x <= tx;
		req.target_y <= ty;
		req.target_z <= tz;
		angles_due.push_back(look_angles(px, py, pz, tx, ty, tz));
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (angles_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		angles_t z20;
		logic [31:0] px, py, pz, dxr, dyr, dzr;
		int mode;

		req.valid = 1'b0;
		req.pos_x = '0;
		req.pos_y = '0;
		req.pos_z = '0;
		req.target_x = '0;
		req.target_y = '0;
		req.target_z = '0;
		rsp.ready = 1'b0;

		// known results: unchanged, straight up/down, dz zero with dx set, dz only
		z20 = '{pitch: 20'sd0, yaw: 20'sd0, unch: 1'b1};
		rows.push_back('{0, 0, 0, 0, 0, 0, 1'b1, z20});
		rows.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, z20});
		rows.push_back('{0, 5, 0, 0, 0, 0, 1'b1, '{20'sd102944, 20'sd0, 1'b0}});
		rows.push_back('{0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 1'b1,
			'{-20'sd102944, 20'sd0, 1'b0}});
		rows.push_back('{7, 0, 0, 0, 0, 0, 1'b1, '{20'sd0, 20'sd102944, 1'b0}});
		rows.push_back('{32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 1'b1,
			'{20'sd0, -20'sd102944, 1'b0}});
		rows.push_back('{0, 0, 1, 0, 0, 0, 1'b1, '{20'sd0, 20'sd205887, 1'b0}});
		rows.push_back('{0, 0, 0, 0, 0, 1, 1'b1, '{20'sd0, 20'sd0, 1'b0}});
		// predicted rows: extremes, halving case, quadrants
		rows.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, z20});
		rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, z20});
		rows.push_back('{32'h7fff_ffff, 1, 0, 32'h8000_0000, 0, 0, 1'b0, z20});
		rows.push_back('{1, 1, 1, 0, 0, 0, 1'b0, z20});
		rows.push_back('{-1, 1, -1, 0, 0, 0, 1'b0, z20});
		rows.push_back('{1, -1, -1, 0, 0, 0, 1'b0, z20});
		rows.push_back('{-1, -1, 1, 0, 0, 0, 1'b0, z20});
		rows.push_back('{32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 0, 0, 0, 1'b0, z20});
		rows.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1'b0, z20});
		rows.push_back('{0, 32'h5555_5555, 32'haaaa_aaaa, 0, 0, 0, 1'b0, z20});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 27;
		recv_idle = 80;
		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.known && look_angles(rw.px, rw.py, rw.pz, rw.tx, rw.ty, rw.tz) != rw.want) begin
				$error("directed row %0d: typed result differs from prediction", i);
				errors++;
			end
			send_item(rw.px, rw.py, rw.pz, rw.tx, rw.ty, rw.tz);
		end
		// hold off until the pipe is empty
		drain();

		for (int n = 0; n < 900; n++) begin
			if (n == 300) begin
				send_idle = 80;
				recv_idle = 27;
			end else if (n == 600) begin
				send_idle = 0;
				recv_idle = 0;
			end
			px = rand_coord();
			py = rand_coord();
			pz = rand_coord();
			mode = $urandom_range(0, 9);
			// small offsets for half the items, some axis-aligned and unchanged cases
			dxr = mode < 5 ? $urandom_range(0, 512) - 256 : $urandom;
			dyr = mode < 5 ? $urandom_range(0, 512) - 256 : $urandom;
			dzr = mode < 5 ? $urandom_range(0, 512) - 256 : $urandom;
			if (mode == 7) dxr = 0;
			if (mode == 8) dzr = 0;
			if (mode == 9) begin
				dxr = 0;
				dzr = 0;
				if ($urandom_range(0, 1)) dyr = 0;
			end
			send_item(px, py, pz, px - dxr, py - dyr, pz - dzr);
		end
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("checked %0d results over directed, quadrant and wrap-around items", checked);
		$display("idle patterns: sender-heavy, receiver-heavy and none, with a full drain");
		if (errors == 0 && angles_due.size() == 0) begin
			$display("look_at_pitch_yaw regression: pass");
		end else begin
			$display("look_at_pitch_yaw regression: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		angles_t exp_a;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (angles_due.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				exp_a = angles_due.pop_front();
				checked++;
				if (rsp.pitch_angle !== exp_a.pitch) begin
					$error("pitch_angle: expected %0d, got %0d", exp_a.pitch, rsp.pitch_angle);
					errors++;
				end
				if (rsp.yaw_angle !== exp_a.yaw) begin
					$error("yaw_angle: expected %0d, got %0d", exp_a.yaw, rsp.yaw_angle);
					errors++;
				end
				if (rsp.unchanged !== exp_a.unch) begin
					$error("unchanged: expected %0b, got %0b", exp_a.unch, rsp.unchanged);
					errors++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("look_at_pitch_yaw regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
